[rtl/ellipse_midpoint_rasterizer_assert.svh]
// Assertion macros used by the ellipse rasterizer top level.
`ifndef ELLIPSE_MIDPOINT_RASTERIZER_ASSERT_SVH
`define ELLIPSE_MIDPOINT_RASTERIZER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define EMR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define EMR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/emr_pkg.sv]
// Shared types, codes and defaults of the midpoint ellipse rasterizer.
`default_nettype none

package emr_pkg;

    // Default geometry of the block.
    localparam int COORD_BITS_DEF  = 12;
    localparam int RADIUS_BITS_DEF = 10;

    // Opcode carried on the input tuser bit.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Drawing phase of the pen.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_R1,
        PH_R2
    } phase_t;

    // Controller states.
    typedef enum logic [4:0] {
        ST_READY,
        ST_SQ_A,
        ST_SQ_B,
        ST_SQ_LIM,
        ST_A2B,
        ST_INIT,
        ST_R1_Y,
        ST_R1_X,
        ST_R2_X,
        ST_R2_Y,
        ST_TXX,
        ST_TSUM,
        ST_TCMP,
        ST_E2B,
        ST_E2A,
        ST_E2F,
        ST_EMIT
    } ctrl_state_t;

    // Register updates the datapath performs per command.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_START,
        DP_SQ_B,
        DP_SQ_LIM,
        DP_A2B,
        DP_INIT,
        DP_STEP,
        DP_R1_Y,
        DP_R1_X,
        DP_R2_X,
        DP_R2_Y,
        DP_E2A,
        DP_E2F,
        DP_EMIT
    } dp_op_t;

    // Operand pair fed to the shared multiplier.
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_AA,
        MUL_BB,
        MUL_A2A2,
        MUL_A2B,
        MUL_XX,
        MUL_PSUM,
        MUL_B2X,
        MUL_A2Y
    } mul_sel_t;

    // Command from controller to datapath.
    typedef struct packed {
        dp_op_t     op;
        mul_sel_t   mul;
        logic [1:0] beat;
    } dp_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic active;
        logic in_r1;
        logic region_one;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/emr_ctrl.sv]
// Sequencing controller of the midpoint ellipse rasterizer.
`default_nettype none

module emr_ctrl
    import emr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_opcode,
    output logic            in_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;
    logic        stepping_reg, stepping_next;
    logic [1:0]  beat_reg, beat_next;

    // State and sequencing registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_READY;
            stepping_reg <= 1'b0;
            beat_reg     <= 2'd0;
        end
        else
        begin
            state_reg    <= state_next;
            stepping_reg <= stepping_next;
            beat_reg     <= beat_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next    = state_reg;
        stepping_next = stepping_reg;
        beat_next     = beat_reg;
        case (state_reg)
            ST_READY:
            begin
                beat_next = 2'd0;
                if (in_valid)
                begin
                    if (in_opcode == OP_START)
                    begin
                        stepping_next = 1'b0;
                        state_next    = ST_SQ_A;
                    end
                    else if (status.active)
                    begin
                        stepping_next = 1'b1;
                        state_next    = status.in_r1 ? ST_R1_Y : ST_R2_X;
                    end
                end
            end
            ST_SQ_A:   state_next = ST_SQ_B;
            ST_SQ_B:   state_next = ST_SQ_LIM;
            ST_SQ_LIM: state_next = ST_A2B;
            ST_A2B:    state_next = ST_INIT;
            ST_INIT:   state_next = ST_TXX;
            ST_R1_Y:   state_next = ST_R1_X;
            ST_R1_X:   state_next = ST_TXX;
            ST_R2_X:   state_next = ST_R2_Y;
            ST_R2_Y:   state_next = ST_EMIT;
            ST_TXX:    state_next = ST_TSUM;
            ST_TSUM:   state_next = ST_TCMP;
            ST_TCMP:
            begin
                if (!status.region_one)
                    state_next = ST_E2B;
                else
                    state_next = stepping_reg ? ST_EMIT : ST_READY;
            end
            ST_E2B:    state_next = ST_E2A;
            ST_E2A:    state_next = ST_E2F;
            ST_E2F:    state_next = stepping_reg ? ST_EMIT : ST_READY;
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    beat_next = beat_reg + 2'd1;
                    if (beat_reg == 2'd3)
                        state_next = ST_READY;
                end
            end
            default:   state_next = ST_READY;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = DP_NOP;
        cmd.mul  = MUL_NONE;
        cmd.beat = beat_reg;
        case (state_reg)
            ST_READY:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_opcode == OP_START)
                        cmd.op = DP_START;
                    else if (status.active)
                        cmd.op = DP_STEP;
                end
            end
            ST_SQ_A:   cmd.mul = MUL_AA;
            ST_SQ_B:
            begin
                cmd.op  = DP_SQ_B;
                cmd.mul = MUL_BB;
            end
            ST_SQ_LIM:
            begin
                cmd.op  = DP_SQ_LIM;
                cmd.mul = MUL_A2A2;
            end
            ST_A2B:
            begin
                cmd.op  = DP_A2B;
                cmd.mul = MUL_A2B;
            end
            ST_INIT:   cmd.op = DP_INIT;
            ST_R1_Y:   cmd.op = DP_R1_Y;
            ST_R1_X:   cmd.op = DP_R1_X;
            ST_R2_X:   cmd.op = DP_R2_X;
            ST_R2_Y:   cmd.op = DP_R2_Y;
            ST_TXX:    cmd.mul = MUL_XX;
            ST_TSUM:   cmd.mul = MUL_PSUM;
            ST_TCMP:   cmd.op = DP_NOP;
            ST_E2B:    cmd.mul = MUL_B2X;
            ST_E2A:
            begin
                cmd.op  = DP_E2A;
                cmd.mul = MUL_A2Y;
            end
            ST_E2F:    cmd.op = DP_E2F;
            ST_EMIT:
            begin
                if (status.out_free)
                    cmd.op = DP_EMIT;
            end
            default:   cmd.op = DP_NOP;
        endcase
    end

endmodule

`default_nettype wire

[rtl/emr_datapath.sv]
// Datapath of the midpoint ellipse rasterizer: pen state, shared multiplier, output stage.
`default_nettype none

module emr_datapath
    import emr_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire dp_cmd_t                        cmd,
    output dp_status_t                          status,
    input  wire logic signed [COORD_BITS-1:0]   center_x,
    input  wire logic signed [COORD_BITS-1:0]   center_y,
    input  wire logic        [RADIUS_BITS-1:0]  semi_a,
    input  wire logic        [RADIUS_BITS-1:0]  semi_b,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [COORD_BITS:0]          point_x,
    output logic signed [COORD_BITS:0]          point_y,
    output logic                                last_point
);

    localparam int R      = RADIUS_BITS;
    localparam int C      = COORD_BITS;
    localparam int SQ_W   = 2 * R;
    localparam int LIM_W  = 4 * R;
    localparam int X_W    = R + 1;
    localparam int Y_W    = R + 2;
    localparam int XI_W   = 3 * R + 6;
    localparam int YI_W   = 3 * R + 7;
    localparam int DEC_W  = 4 * R + 6;
    localparam int MUL_W  = 2 * R + 4;
    localparam int PROD_W = 2 * MUL_W;
    localparam int PT_W   = C + R + 3;

    // Pen and ellipse state.
    logic signed [C-1:0]      ox_reg, ox_next;
    logic signed [C-1:0]      oy_reg, oy_next;
    logic        [R-1:0]      a_reg, a_next;
    logic        [R-1:0]      b_reg, b_next;
    logic        [SQ_W-1:0]   a2_reg, a2_next;
    logic        [SQ_W-1:0]   b2_reg, b2_next;
    logic        [SQ_W:0]     sum_reg, sum_next;
    logic        [LIM_W-1:0]  lim_reg, lim_next;
    logic        [X_W-1:0]    x_reg, x_next;
    logic signed [Y_W-1:0]    y_reg, y_next;
    logic        [XI_W-1:0]   xi_reg, xi_next;
    logic signed [YI_W-1:0]   yi_reg, yi_next;
    logic signed [DEC_W-1:0]  dec_reg, dec_next;
    phase_t                   ph_reg, ph_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    // Snapshot of the point being emitted and the output stage.
    logic        [X_W-1:0]    sx_reg, sx_next;
    logic signed [Y_W-1:0]    sy_reg, sy_next;
    logic                     last_reg, last_next;
    logic signed [C:0]        px_reg, px_next;
    logic signed [C:0]        py_reg, py_next;
    logic                     pl_reg, pl_next;
    logic                     ov_reg, ov_next;

    // Operands and derived terms.
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [Y_W-1:0]    y_dn;
    logic signed [DEC_W-1:0]  a2_dec, b2_dec, prod_dec, xi_step_dec, yi_step_dec;
    logic        [XI_W-1:0]   xi_step;
    logic signed [YI_W-1:0]   yi_step;
    logic signed [PT_W-1:0]   cx_w, cy_w, x_w, y_w, px_w, py_w;

    // Multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul)
            MUL_AA:
            begin
                mul_a = {{(MUL_W-R){1'b0}}, a_reg};
                mul_b = {{(MUL_W-R){1'b0}}, a_reg};
            end
            MUL_BB:
            begin
                mul_a = {{(MUL_W-R){1'b0}}, b_reg};
                mul_b = {{(MUL_W-R){1'b0}}, b_reg};
            end
            MUL_A2A2:
            begin
                mul_a = {{(MUL_W-SQ_W){1'b0}}, a2_reg};
                mul_b = {{(MUL_W-SQ_W){1'b0}}, a2_reg};
            end
            MUL_A2B:
            begin
                mul_a = {{(MUL_W-SQ_W){1'b0}}, a2_reg};
                mul_b = {{(MUL_W-R){1'b0}}, b_reg};
            end
            MUL_XX:
            begin
                mul_a = {{(MUL_W-X_W){1'b0}}, x_reg};
                mul_b = {{(MUL_W-X_W){1'b0}}, x_reg};
            end
            MUL_PSUM:
            begin
                mul_a = prod_reg[MUL_W-1:0];
                mul_b = {{(MUL_W-SQ_W-1){1'b0}}, sum_reg};
            end
            MUL_B2X:
            begin
                // 4x + 3
                mul_a = {{(MUL_W-SQ_W){1'b0}}, b2_reg};
                mul_b = {{(MUL_W-X_W-2){1'b0}}, x_reg, 2'b11};
            end
            MUL_A2Y:
            begin
                // 4y - 3 is 4(y - 1) + 1
                mul_a = {{(MUL_W-SQ_W){1'b0}}, a2_reg};
                mul_b = {{(MUL_W-Y_W-2){y_dn[Y_W-1]}}, y_dn, 2'b01};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Derived terms for the decision updates.
    always_comb
    begin
        y_dn        = y_reg - Y_W'(1);
        a2_dec      = {{(DEC_W-SQ_W){1'b0}}, a2_reg};
        b2_dec      = {{(DEC_W-SQ_W){1'b0}}, b2_reg};
        prod_dec    = prod_reg[DEC_W-1:0];
        xi_step     = xi_reg + {{(XI_W-SQ_W-1){1'b0}}, b2_reg, 1'b0};
        yi_step     = yi_reg + {{(YI_W-SQ_W-1){1'b0}}, a2_reg, 1'b0};
        xi_step_dec = {{(DEC_W-XI_W){1'b0}}, xi_step};
        yi_step_dec = {{(DEC_W-YI_W){yi_step[YI_W-1]}}, yi_step};
        prod_next   = mul_a * mul_b;
    end

    // Mirrored point of the current beat.
    always_comb
    begin
        cx_w = {{(PT_W-C){ox_reg[C-1]}}, ox_reg};
        cy_w = {{(PT_W-C){oy_reg[C-1]}}, oy_reg};
        x_w  = {{(PT_W-X_W){1'b0}}, sx_reg};
        y_w  = {{(PT_W-Y_W){sy_reg[Y_W-1]}}, sy_reg};
        px_w = cmd.beat[1] ? (cx_w - x_w) : (cx_w + x_w);
        py_w = cmd.beat[0] ? (cy_w - y_w) : (cy_w + y_w);
    end

    // Register updates per command.
    always_comb
    begin
        ox_next   = ox_reg;
        oy_next   = oy_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        a2_next   = a2_reg;
        b2_next   = b2_reg;
        sum_next  = sum_reg;
        lim_next  = lim_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        xi_next   = xi_reg;
        yi_next   = yi_reg;
        dec_next  = dec_reg;
        ph_next   = ph_reg;
        sx_next   = sx_reg;
        sy_next   = sy_reg;
        last_next = last_reg;
        px_next   = px_reg;
        py_next   = py_reg;
        pl_next   = pl_reg;
        ov_next   = ov_reg && !out_ready;
        case (cmd.op)
            DP_START:
            begin
                ox_next = center_x;
                oy_next = center_y;
                a_next  = semi_a;
                b_next  = semi_b;
                x_next  = '0;
                y_next  = {2'b00, semi_b};
                xi_next = '0;
                ph_next = PH_R1;
            end
            DP_SQ_B:
                a2_next = prod_reg[SQ_W-1:0];
            DP_SQ_LIM:
            begin
                b2_next  = prod_reg[SQ_W-1:0];
                sum_next = {1'b0, a2_reg} + {1'b0, prod_reg[SQ_W-1:0]};
            end
            DP_A2B:
                lim_next = prod_reg[LIM_W-1:0];
            DP_INIT:
            begin
                // prod holds a^2 * b
                yi_next  = -(prod_reg[YI_W-1:0] <<< 1);
                dec_next = (b2_dec <<< 2) - (prod_dec <<< 2) + a2_dec;
            end
            DP_STEP:
            begin
                sx_next   = x_reg;
                sy_next   = y_reg;
                last_next = 1'b0;
            end
            DP_R1_Y:
            begin
                if (dec_reg > 0)
                begin
                    y_next   = y_dn;
                    yi_next  = yi_step;
                    dec_next = dec_reg + (yi_step_dec <<< 2);
                end
            end
            DP_R1_X:
            begin
                x_next   = x_reg + X_W'(1);
                xi_next  = xi_step;
                dec_next = dec_reg + ((xi_step_dec + b2_dec) <<< 2);
            end
            DP_R2_X:
            begin
                if (dec_reg <= 0)
                begin
                    x_next   = x_reg + X_W'(1);
                    xi_next  = xi_step;
                    dec_next = dec_reg + (xi_step_dec <<< 2);
                end
            end
            DP_R2_Y:
            begin
                y_next   = y_dn;
                yi_next  = yi_step;
                dec_next = dec_reg + ((a2_dec + yi_step_dec) <<< 2);
                if (y_dn[Y_W-1])
                begin
                    ph_next   = PH_IDLE;
                    last_next = 1'b1;
                end
            end
            DP_E2A:
                dec_next = dec_reg - prod_dec;
            DP_E2F:
            begin
                dec_next = dec_reg - prod_dec;
                ph_next  = PH_R2;
                // A flat ellipse can leave region one already below the axis.
                if (y_reg[Y_W-1])
                begin
                    ph_next   = PH_IDLE;
                    last_next = 1'b1;
                end
            end
            DP_EMIT:
            begin
                px_next = px_w[C:0];
                py_next = py_w[C:0];
                pl_next = last_reg && (cmd.beat == 2'd3);
                ov_next = 1'b1;
            end
            default:
                ov_next = ov_reg && !out_ready;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            ph_reg <= ph_next;
            ov_reg <= ov_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        a2_reg   <= a2_next;
        b2_reg   <= b2_next;
        sum_reg  <= sum_next;
        lim_reg  <= lim_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        xi_reg   <= xi_next;
        yi_reg   <= yi_next;
        dec_reg  <= dec_next;
        prod_reg <= prod_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        last_reg <= last_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        pl_reg   <= pl_next;
    end

    // Status and output stage.
    always_comb
    begin
        status.active     = (ph_reg != PH_IDLE);
        status.in_r1      = (ph_reg == PH_R1);
        // Zero by zero ellipse never counts as region one.
        status.region_one = (sum_reg != '0) &&
                            (prod_reg <= $signed({{(PROD_W-LIM_W){1'b0}}, lim_reg}));
        status.out_free   = !ov_reg || out_ready;
        out_valid         = ov_reg;
        point_x           = px_reg;
        point_y           = py_reg;
        last_point        = pl_reg;
    end

endmodule

`default_nettype wire

[rtl/ellipse_midpoint_rasterizer.sv]
// Midpoint ellipse rasterizer: top level joining controller and datapath.
//
// Input channel s_axis: one beat is a command. tuser = 0 starts a new ellipse from
// the center and semi-axes in tdata; tuser = 1 asks for one pen step. A start
// produces no output; a step produces four output beats, the mirrored points
// (cx+x,cy+y), (cx+x,cy-y), (cx-x,cy+y), (cx-x,cy-y). tlast marks the final point
// of the ellipse. Steps while no ellipse is active are taken and produce nothing.
// Output channel m_axis: one registered point per beat.
// A start squares the semi-axes, forms the region limit and a^2*b, sets up the
// decision and tests the region, then sets up the region-two decision when the
// ellipse begins in region two. A region-one step updates y and x and tests the
// region again, setting up the region-two decision on the step that crosses into
// region two; a region-two step updates x and y. The single shared multiplier is
// walked through the products one per cycle, and the output stage loads one point
// per cycle while the receiver keeps up. A new command is taken right after
// the fourth beat is loaded, while that beat may still wait in the output register.
// When the receiver stalls, emission waits beat by beat and nothing is lost.
// Reset (rst_n low, asynchronous) drops any ellipse in progress and empties the
// output register.
`default_nettype none

`include "ellipse_midpoint_rasterizer_assert.svh"

module ellipse_midpoint_rasterizer
    import emr_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF,
    localparam int S_DATA_W   = ((2 * COORD_BITS + 2 * RADIUS_BITS + 7) / 8) * 8,
    localparam int M_DATA_W   = ((2 * (COORD_BITS + 1) + 7) / 8) * 8
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // center_x, center_y, semi_a, semi_b, zero padding
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    // opcode
    input  wire logic                s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // point_x, point_y, zero padding
    output logic [M_DATA_W-1:0]      m_axis_tdata,
    // last_point
    output logic                     m_axis_tlast
);

    localparam int C = COORD_BITS;
    localparam int R = RADIUS_BITS;

    dp_cmd_t           cmd;
    dp_status_t        status;
    logic signed [C:0] point_x;
    logic signed [C:0] point_y;
    logic              cmd_is_take;
    logic              step_taken;

    emr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_opcode (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    emr_datapath #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .center_x   (s_axis_tdata[C-1:0]),
        .center_y   (s_axis_tdata[2*C-1:C]),
        .semi_a     (s_axis_tdata[2*C+R-1:2*C]),
        .semi_b     (s_axis_tdata[2*C+2*R-1:2*C+R]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (m_axis_tlast)
    );

    // Pack the output beat.
    assign m_axis_tdata = M_DATA_W'({point_y, point_x});

    // Conditions watched by the assertions.
    assign cmd_is_take = (cmd.op == DP_NOP) || (cmd.op == DP_START) || (cmd.op == DP_STEP);
    assign step_taken  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_STEP) &&
                         status.active;

    // Commands are only taken in the ready state, which issues no arithmetic.
    `EMR_ASSERT_NOW(a_ready_cmd, s_axis_tready, cmd_is_take, "arithmetic in the ready state")

    // A point is loaded only when the output register can take it.
    `EMR_ASSERT_NOW(a_emit_free, cmd.op == DP_EMIT, status.out_free, "point over unread beat")

    // A step on an active ellipse always starts a busy sequence.
    `EMR_ASSERT_NEXT(a_step_busy, step_taken, !s_axis_tready, "active step did not start")

endmodule

`default_nettype wire
